>>> hdl/mbrot_pkg.sv
package mbrot_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int VAL_W       = FRAC_BITS + 4;
   localparam int RES_W       = 13;
   localparam int MAX_RES     = 4096;
   localparam int ITER_W      = 16;
   localparam int MAG_W       = 32;
   localparam int ADDR_W      = 24;
   localparam int COLOR_W     = 6;
   localparam int NUM_W       = 31;
   localparam int DEN_W       = RES_W + MAG_W;
   localparam int QUO_W       = VAL_W - 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      REG_MAX_ITER = 3'd0,
      REG_MAGNIFY  = 3'd1,
      REG_X_CENTER = 3'd2,
      REG_Y_CENTER = 3'd3,
      REG_H_RES    = 3'd4,
      REG_V_RES    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] cx;
      logic signed [VAL_W-1:0] cy;
      logic [ADDR_W-1:0]       addr_direct;
      logic [ADDR_W-1:0]       addr_mirror;
      logic                    mirror;
   } job_type;

   typedef enum logic [2:0] {
      F_IDLE, F_DIV_X, F_WAIT_X, F_DIV_Y, F_WAIT_Y, F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_MUL, B_STEP, B_EMIT_D, B_EMIT_M
   } back_state_type;

   function automatic logic signed [VAL_W-1:0] sat_add(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s > $signed({VMAX[VAL_W-1], VMAX})) return VMAX;
      if (s < $signed({VMIN[VAL_W-1], VMIN})) return VMIN;
      return s[VAL_W-1:0];
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_sub(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      if (s > $signed({VMAX[VAL_W-1], VMAX})) return VMAX;
      if (s < $signed({VMIN[VAL_W-1], VMIN})) return VMIN;
      return s[VAL_W-1:0];
   endfunction

endpackage

>>> hdl/mandelbrot_escape_time_pixel.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_column, req_row (13 bits each)
// rsp       out        rsp_valid/rsp_stall  rsp_pixel_address (24), rsp_color (6), rsp_last
// csr       in/out     psel/penable/pready  paddr (5), pwdata/prdata (32)
//
// The front takes one pixel at a time and maps it to the plane: one shared
// restoring divider yields the x offset, then the y offset, one quotient bit
// per cycle, while the addresses are formed alongside. A two-entry queue
// hands the work to the back, which runs z = z*z + c in the states B_MUL
// (square and cross products) and B_STEP (add and escape test). Results
// leave through an output register, so the back goes on to the next pixel
// while a stalled result waits there, holding only to emit another one; the
// front keeps taking pixels until the queue is full.
// Reset is synchronous and loads the default view into the control registers.
module mandelbrot_escape_time_pixel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mbrot_pkg::RES_W-1:0]         req_column,
   input  logic [mbrot_pkg::RES_W-1:0]         req_row,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mbrot_pkg::ADDR_W-1:0]        rsp_pixel_address,
   output logic [mbrot_pkg::COLOR_W-1:0]       rsp_color,
   output logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [4:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // configuration registers
   logic [mbrot_pkg::ITER_W-1:0]        max_iter_ff, max_iter_in;
   logic [mbrot_pkg::MAG_W-1:0]         magnify_ff, magnify_in;
   logic signed [mbrot_pkg::VAL_W-1:0]  x_center_ff, x_center_in;
   logic signed [mbrot_pkg::VAL_W-1:0]  y_center_ff, y_center_in;
   logic [mbrot_pkg::RES_W-1:0]         h_res_ff, h_res_in;
   logic [mbrot_pkg::RES_W-1:0]         v_res_ff, v_res_in;
   logic                                wr_en;
   logic [mbrot_pkg::RES_W-1:0]         res_clamped;
   mbrot_pkg::reg_index_type            reg_sel;

   logic                                q_push, q_pop, q_full, q_empty;
   mbrot_pkg::job_type                  q_wdata, q_rdata;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = mbrot_pkg::reg_index_type'(paddr[4:2]);
   // clamp resolution writes to the largest supported frame
   assign res_clamped = (pwdata[mbrot_pkg::RES_W-1:0] > mbrot_pkg::RES_W'(mbrot_pkg::MAX_RES))
                        ? mbrot_pkg::RES_W'(mbrot_pkg::MAX_RES)
                        : pwdata[mbrot_pkg::RES_W-1:0];

   always_comb begin
      max_iter_in = max_iter_ff;
      magnify_in  = magnify_ff;
      x_center_in = x_center_ff;
      y_center_in = y_center_ff;
      h_res_in    = h_res_ff;
      v_res_in    = v_res_ff;
      if (wr_en) begin
         unique case (reg_sel)
            mbrot_pkg::REG_MAX_ITER: max_iter_in = pwdata[mbrot_pkg::ITER_W-1:0];
            mbrot_pkg::REG_MAGNIFY:  magnify_in  = pwdata;
            mbrot_pkg::REG_X_CENTER: x_center_in = pwdata;
            mbrot_pkg::REG_Y_CENTER: y_center_in = pwdata;
            mbrot_pkg::REG_H_RES:    h_res_in    = res_clamped;
            mbrot_pkg::REG_V_RES:    v_res_in    = res_clamped;
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         mbrot_pkg::REG_MAX_ITER: prdata = 32'(max_iter_ff);
         mbrot_pkg::REG_MAGNIFY:  prdata = magnify_ff;
         mbrot_pkg::REG_X_CENTER: prdata = x_center_ff;
         mbrot_pkg::REG_Y_CENTER: prdata = y_center_ff;
         mbrot_pkg::REG_H_RES:    prdata = 32'(h_res_ff);
         mbrot_pkg::REG_V_RES:    prdata = 32'(v_res_ff);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= 16'd256;
         magnify_ff  <= 32'd65536;
         x_center_ff <= '0;
         y_center_ff <= '0;
         h_res_ff    <= 13'd800;
         v_res_ff    <= 13'd600;
      end else begin
         max_iter_ff <= max_iter_in;
         magnify_ff  <= magnify_in;
         x_center_ff <= x_center_in;
         y_center_ff <= y_center_in;
         h_res_ff    <= h_res_in;
         v_res_ff    <= v_res_in;
      end
   end

   // front: accept, map to the plane, form addresses
   mbrot_front u_front (
      .clock      (clock),
      .reset      (reset),
      .magnify    (magnify_ff),
      .x_center   (x_center_ff),
      .y_center   (y_center_ff),
      .h_res      (h_res_ff),
      .v_res      (v_res_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_column (req_column),
      .req_row    (req_row),
      .queue_full (q_full),
      .push       (q_push),
      .job        (q_wdata)
   );

   // hold mapped pixels between the two halves
   mbrot_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .job_in  (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .job_out (q_rdata),
      .empty   (q_empty)
   );

   // back: iterate and emit the direct and mirrored results
   mbrot_back u_back (
      .clock             (clock),
      .reset             (reset),
      .max_iter          (max_iter_ff),
      .queue_empty       (q_empty),
      .job_in_q          (q_rdata),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_color         (rsp_color),
      .rsp_last          (rsp_last)
   );

endmodule

>>> hdl/mbrot_div.sv
module mbrot_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mbrot_pkg::NUM_W-1:0]  num,
   input  logic [mbrot_pkg::DEN_W-1:0]  den,
   output logic                         done,
   output logic [mbrot_pkg::QUO_W-1:0]  quot
);

   localparam int CNT_W = $clog2(mbrot_pkg::QUO_W + 1);

   logic [mbrot_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [mbrot_pkg::DEN_W-1:0] den_ff, den_in;
   logic [mbrot_pkg::QUO_W-1:0] bits_ff, bits_in;
   logic [mbrot_pkg::QUO_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [mbrot_pkg::DEN_W:0]   trial;
   logic [mbrot_pkg::DEN_W:0]   diff;
   logic                        ge;
   logic                        ovf;

   assign trial = {rem_ff, bits_ff[mbrot_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};
   // quotient would not fit below 2^31: num*2^28 >= den*2^31
   assign ovf   = {{(mbrot_pkg::DEN_W + 3 - mbrot_pkg::NUM_W){1'b0}}, num} >= {den, 3'b000};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         den_in = den;
         if (num == '0) begin
            quot_in = '0;
            done_in = 1'b1;
         end else if (ovf) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = {{(mbrot_pkg::DEN_W - mbrot_pkg::NUM_W + 3){1'b0}},
                       num[mbrot_pkg::NUM_W-1:3]};
            bits_in = {num[2:0], {(mbrot_pkg::QUO_W - 3){1'b0}}};
            quot_in = '0;
            cnt_in  = CNT_W'(mbrot_pkg::QUO_W);
            run_in  = 1'b1;
         end
      end else if (run_ff) begin
         rem_in  = ge ? diff[mbrot_pkg::DEN_W-1:0] : trial[mbrot_pkg::DEN_W-1:0];
         bits_in = {bits_ff[mbrot_pkg::QUO_W-2:0], 1'b0};
         quot_in = {quot_ff[mbrot_pkg::QUO_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> hdl/mbrot_front.sv
module mbrot_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mbrot_pkg::MAG_W-1:0]         magnify,
   input  logic signed [mbrot_pkg::VAL_W-1:0]  x_center,
   input  logic signed [mbrot_pkg::VAL_W-1:0]  y_center,
   input  logic [mbrot_pkg::RES_W-1:0]         h_res,
   input  logic [mbrot_pkg::RES_W-1:0]         v_res,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mbrot_pkg::RES_W-1:0]         req_column,
   input  logic [mbrot_pkg::RES_W-1:0]         req_row,
   input  logic                                queue_full,
   output logic                                push,
   output mbrot_pkg::job_type                  job
);

   mbrot_pkg::front_state_type state_ff, state_in;
   logic [mbrot_pkg::RES_W-1:0]        col_ff, col_in;
   logic [mbrot_pkg::RES_W-1:0]        row_ff, row_in;
   logic                               neg_ff, neg_in;
   mbrot_pkg::job_type                 job_ff, job_in;
   logic                               div_start;
   logic                               div_done;
   logic [mbrot_pkg::QUO_W-1:0]        div_quot;
   logic [mbrot_pkg::RES_W-1:0]        sel_p;
   logic [mbrot_pkg::RES_W-1:0]        sel_res;
   logic signed [mbrot_pkg::RES_W+2:0] n_val;
   logic [mbrot_pkg::RES_W+1:0]        n_mag;
   logic [mbrot_pkg::RES_W+3:0]        n_mag3;
   logic [mbrot_pkg::NUM_W-1:0]        div_num;
   logic [mbrot_pkg::DEN_W-1:0]        div_den;
   logic signed [mbrot_pkg::VAL_W-1:0] offset;
   logic [mbrot_pkg::ADDR_W-1:0]       col_x, row_x, hres_x, vres_x;

   // x offset first, then y
   assign sel_p   = (state_ff == mbrot_pkg::F_DIV_Y) ? row_ff : col_ff;
   assign sel_res = (state_ff == mbrot_pkg::F_DIV_Y) ? v_res : h_res;
   assign n_val   = {1'b0, sel_p, 1'b0} - {2'b00, sel_res};
   assign n_mag   = n_val[mbrot_pkg::RES_W+2] ? (mbrot_pkg::RES_W+2)'(-n_val)
                                             : n_val[mbrot_pkg::RES_W+1:0];
   assign n_mag3  = {1'b0, n_mag, 1'b0} + {2'b00, n_mag};
   assign div_num = {n_mag3[mbrot_pkg::NUM_W-16:0], 15'b0};
   assign div_den = {{mbrot_pkg::MAG_W{1'b0}}, sel_res} * {{mbrot_pkg::RES_W{1'b0}}, magnify};
   assign offset  = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

   assign col_x  = mbrot_pkg::ADDR_W'(col_ff);
   assign row_x  = mbrot_pkg::ADDR_W'(row_ff);
   assign hres_x = mbrot_pkg::ADDR_W'(h_res);
   assign vres_x = mbrot_pkg::ADDR_W'(v_res);

   mbrot_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      neg_in    = neg_ff;
      job_in    = job_ff;
      div_start = 1'b0;
      push      = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         mbrot_pkg::F_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               col_in   = req_column;
               row_in   = req_row;
               state_in = mbrot_pkg::F_DIV_X;
            end
         end
         mbrot_pkg::F_DIV_X: begin
            div_start          = 1'b1;
            neg_in             = n_val[mbrot_pkg::RES_W+2];
            job_in.addr_direct = mbrot_pkg::ADDR_W'(hres_x * (row_x - 24'd1))
                                 + col_x - 24'd1;
            job_in.addr_mirror = mbrot_pkg::ADDR_W'(hres_x * (vres_x - row_x))
                                 + col_x - 24'd1;
            job_in.mirror      = (y_center == '0);
            state_in           = mbrot_pkg::F_WAIT_X;
         end
         mbrot_pkg::F_WAIT_X: begin
            if (div_done) begin
               job_in.cx = mbrot_pkg::sat_add(offset, x_center);
               state_in  = mbrot_pkg::F_DIV_Y;
            end
         end
         mbrot_pkg::F_DIV_Y: begin
            div_start = 1'b1;
            neg_in    = n_val[mbrot_pkg::RES_W+2];
            state_in  = mbrot_pkg::F_WAIT_Y;
         end
         mbrot_pkg::F_WAIT_Y: begin
            if (div_done) begin
               job_in.cy = mbrot_pkg::sat_sub(offset, y_center);
               state_in  = mbrot_pkg::F_PUSH;
            end
         end
         mbrot_pkg::F_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = mbrot_pkg::F_IDLE;
            end
         end
         default: state_in = mbrot_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbrot_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff <= col_in;
      row_ff <= row_in;
      neg_ff <= neg_in;
      job_ff <= job_in;
   end

   assign job = job_ff;

endmodule

>>> hdl/mbrot_queue.sv
module mbrot_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mbrot_pkg::job_type job_in,
   output logic               full,
   input  logic               pop,
   output mbrot_pkg::job_type job_out,
   output logic               empty
);

   localparam int PTR_W = $clog2(mbrot_pkg::QUEUE_DEPTH);

   mbrot_pkg::job_type mem_ff [mbrot_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;

   assign full    = (cnt_ff == (PTR_W+1)'(mbrot_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign job_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= job_in;
      end
   end

endmodule

>>> hdl/mbrot_back.sv
module mbrot_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mbrot_pkg::ITER_W-1:0]         max_iter,
   input  logic                                 queue_empty,
   input  mbrot_pkg::job_type                   job_in_q,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mbrot_pkg::ADDR_W-1:0]         rsp_pixel_address,
   output logic [mbrot_pkg::COLOR_W-1:0]        rsp_color,
   output logic                                 rsp_last
);

   localparam int VW = mbrot_pkg::VAL_W;
   localparam int PW = 2 * VW;
   localparam int FB = mbrot_pkg::FRAC_BITS;

   mbrot_pkg::back_state_type state_ff, state_in;
   mbrot_pkg::job_type             job_ff, job_in;
   logic signed [VW-1:0]           x_ff, x_in, y_ff, y_in;
   logic [mbrot_pkg::ITER_W-1:0]   count_ff, count_in;
   logic [PW-1:0]                  pxx_ff, pxx_in, pyy_ff, pyy_in, pxy_ff, pxy_in;
   logic                           negxy_ff, negxy_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mbrot_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [mbrot_pkg::COLOR_W-1:0]  color_ff, color_in;
   logic                           last_ff, last_in;
   logic [VW-1:0]                  mag_x, mag_y;
   logic [VW-2:0]                  xs, ys, xym;
   logic signed [VW-1:0]           xy_s;
   logic [VW-1:0]                  mag_sum;
   logic                           escape;
   logic                           out_free;
   logic [mbrot_pkg::COLOR_W-1:0]  color;

   assign mag_x   = x_ff[VW-1] ? VW'(-x_ff) : VW'(x_ff);
   assign mag_y   = y_ff[VW-1] ? VW'(-y_ff) : VW'(y_ff);
   // truncate squares by FB bits and the cross term by FB-1, saturate
   assign xs      = (pxx_ff[PW-1:FB+VW-1] != '0) ? '1 : pxx_ff[FB+VW-2:FB];
   assign ys      = (pyy_ff[PW-1:FB+VW-1] != '0) ? '1 : pyy_ff[FB+VW-2:FB];
   assign xym     = (pxy_ff[PW-1:FB+VW-2] != '0) ? '1 : pxy_ff[FB+VW-3:FB-1];
   assign xy_s    = negxy_ff ? -$signed({1'b0, xym}) : $signed({1'b0, xym});
   assign mag_sum = {1'b0, xs} + {1'b0, ys};
   assign escape  = mag_sum > (VW'(4) << FB);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign color   = (count_ff == max_iter) ? '0 : count_ff[mbrot_pkg::COLOR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      count_in     = count_ff;
      pxx_in       = pxx_ff;
      pyy_in       = pyy_ff;
      pxy_in       = pxy_ff;
      negxy_in     = negxy_ff;
      addr_in      = addr_ff;
      color_in     = color_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         mbrot_pkg::B_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = job_in_q;
               x_in     = '0;
               y_in     = '0;
               count_in = mbrot_pkg::ITER_W'(1);
               state_in = mbrot_pkg::B_MUL;
            end
         end
         mbrot_pkg::B_MUL: begin
            if (count_ff >= max_iter) begin
               state_in = mbrot_pkg::B_EMIT_D;
            end else begin
               pxx_in   = {{VW{1'b0}}, mag_x} * {{VW{1'b0}}, mag_x};
               pyy_in   = {{VW{1'b0}}, mag_y} * {{VW{1'b0}}, mag_y};
               pxy_in   = {{VW{1'b0}}, mag_x} * {{VW{1'b0}}, mag_y};
               negxy_in = x_ff[VW-1] != y_ff[VW-1];
               state_in = mbrot_pkg::B_STEP;
            end
         end
         mbrot_pkg::B_STEP: begin
            if (escape) begin
               state_in = mbrot_pkg::B_EMIT_D;
            end else begin
               y_in     = mbrot_pkg::sat_add(xy_s, job_ff.cy);
               x_in     = mbrot_pkg::sat_add($signed({1'b0, xs}) - $signed({1'b0, ys}),
                                             job_ff.cx);
               count_in = count_ff + mbrot_pkg::ITER_W'(1);
               state_in = mbrot_pkg::B_MUL;
            end
         end
         mbrot_pkg::B_EMIT_D: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               addr_in      = job_ff.addr_direct;
               color_in     = color;
               last_in      = !job_ff.mirror;
               state_in     = job_ff.mirror ? mbrot_pkg::B_EMIT_M : mbrot_pkg::B_IDLE;
            end
         end
         mbrot_pkg::B_EMIT_M: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               addr_in      = job_ff.addr_mirror;
               color_in     = color;
               last_in      = 1'b1;
               state_in     = mbrot_pkg::B_IDLE;
            end
         end
         default: state_in = mbrot_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbrot_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff   <= job_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      count_ff <= count_in;
      pxx_ff   <= pxx_in;
      pyy_ff   <= pyy_in;
      pxy_ff   <= pxy_in;
      negxy_ff <= negxy_in;
      addr_ff  <= addr_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_color         = color_ff;
   assign rsp_last          = last_ff;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   import mbrot_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam longint VAL_MAX = 64'sd2147483647;
   localparam longint VAL_MIN = -64'sd2147483648;

   // One expected result: address, color and end-of-item flag.
   typedef struct {
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_result_type;

   // Mirror of the register file plus the escape-time predictor and the
   // queue of results still owed by the block.
   class escape_scoreboard;
      int unsigned    max_iter = 256;
      longint         magnify = 65536;
      longint         x_center = 0;
      longint         y_center = 0;
      longint         h_res = 800;
      longint         v_res = 600;
      pixel_result_type pending[$];
      int             mismatches = 0;
      int             results_seen = 0;
      int             mirrored_seen = 0;

      function void set_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_MAX_ITER: max_iter = value[15:0];
            REG_MAGNIFY:  magnify = longint'({32'd0, value});
            REG_X_CENTER: x_center = longint'(signed'(value));
            REG_Y_CENTER: y_center = longint'(signed'(value));
            REG_H_RES:    h_res = (value[12:0] > MAX_RES) ? MAX_RES : value[12:0];
            REG_V_RES:    v_res = (value[12:0] > MAX_RES) ? MAX_RES : value[12:0];
            default: ;
         endcase
      endfunction

      function longint clip(longint v);
         if (v > VAL_MAX) return VAL_MAX;
         if (v < VAL_MIN) return VAL_MIN;
         return v;
      endfunction

      // Truncate the magnitude, clamp positive side, negate for mixed signs.
      function longint qmul(longint a, longint b, int sh);
         longint unsigned ma, mb, p;
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         p = (ma * mb) >> sh;
         if (p > VAL_MAX) p = VAL_MAX;
         return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
      endfunction

      function longint plane_offset(longint p, longint res);
         longint n;
         longint unsigned d, num, q;
         n = 2 * p - res;
         d = res * magnify;
         if (n == 0) return 0;
         if (d == 0) return (n < 0) ? -VAL_MAX : VAL_MAX;
         num = ((n < 0) ? -n : n) * 3 * 32768;
         q = (num << FRAC_BITS) / d;
         if (q > VAL_MAX) q = VAL_MAX;
         return (n < 0) ? -longint'(q) : longint'(q);
      endfunction

      function void note_pixel(logic [RES_W-1:0] col, logic [RES_W-1:0] row);
         longint cx, cy, x, y, xs, ys, y_next;
         longint unsigned base;
         int unsigned cnt;
         pixel_result_type r;
         cx = clip(plane_offset(col, h_res) + x_center);
         cy = clip(plane_offset(row, v_res) - y_center);
         x = 0;
         y = 0;
         for (cnt = 1; cnt < max_iter; cnt++) begin
            xs = qmul(x, x, FRAC_BITS);
            ys = qmul(y, y, FRAC_BITS);
            if (xs + ys > (64'sd4 << FRAC_BITS)) break;
            y_next = clip(qmul(x, y, FRAC_BITS - 1) + cy);
            x = clip(clip(xs - ys) + cx);
            y = y_next;
         end
         r.color = (cnt == max_iter) ? '0 : cnt[COLOR_W-1:0];
         base = h_res * (longint'(row) - 1) + col - 1;
         r.pixel_address = base[ADDR_W-1:0];
         r.last = (y_center != 0);
         pending.push_back(r);
         if (y_center == 0) begin
            base = h_res * (v_res - row) + col - 1;
            r.pixel_address = base[ADDR_W-1:0];
            r.last = 1'b1;
            pending.push_back(r);
         end
      endfunction

      function void check_result(logic [ADDR_W-1:0] addr, logic [COLOR_W-1:0] color,
                                 logic last);
         pixel_result_type e;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: addr %0d color %0d last %0b", addr, color, last);
            return;
         end
         e = pending.pop_front();
         if (!e.last) mirrored_seen++;
         if (addr !== e.pixel_address || color !== e.color || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected addr %0d color %0d last %0b, got %0d %0d %0b",
                        e.pixel_address, e.color, e.last, addr, color, last);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [RES_W-1:0]     req_column = '0;
   logic [RES_W-1:0]     req_row = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ADDR_W-1:0]    rsp_pixel_address;
   logic [COLOR_W-1:0]   rsp_color;
   logic                 rsp_last;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [4:0]           paddr = '0;
   logic [31:0]          pwdata = '0;
   logic [31:0]          prdata;
   logic                 pready;

   escape_scoreboard sb = new();
   int  cycles = 0;
   int  pixels_sent = 0;
   int  stall_left = 0;
   bit  steady = 1'b0;   // no idling on either side while set

   mandelbrot_escape_time_pixel dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results owed", cycles, sb.pending.size());
         $display("[mandelbrot_escape_time_pixel] ERROR");
         $finish;
      end
   end

   // Check every result taken at this edge.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_pixel_address, rsp_color, rsp_last);

   // Receiver back-pressure: mostly short stalls, a few long ones.
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (steady || r < 70) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
         rsp_stall <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Setup cycle, then access cycle; the write lands at the edge after it.
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 5'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   // Drain outstanding results, then let the pipeline settle.
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_pixel(int col, int row);
      int gap;
      req_valid <= 1'b1;
      req_column <= col[RES_W-1:0];
      req_row <= row[RES_W-1:0];
      do @(posedge clock); while (req_stall);
      sb.note_pixel(col[RES_W-1:0], row[RES_W-1:0]);
      pixels_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic finish_burst();
      req_valid <= 1'b0;
      drain();
   endtask

   // Mostly pixels inside the frame; a few anywhere in the 13-bit field.
   task automatic random_pixels(int n);
      int col, row, rows;
      for (int i = 0; i < n; i++) begin
         rows = (sb.y_center == 0) ? (sb.v_res + 1) / 2 : sb.v_res;
         if ($urandom_range(0, 9) == 0) begin
            col = $urandom_range(0, 8191);
            row = $urandom_range(0, 8191);
         end else begin
            col = $urandom_range(1, (sb.h_res > 0) ? sb.h_res : 1);
            row = $urandom_range(1, (rows > 0) ? rows : 1);
         end
         send_pixel(col, row);
         // Hold off once in a while until everything has come back.
         if ($urandom_range(0, 199) == 0) begin
            req_valid <= 1'b0;
            drain();
         end
      end
      finish_burst();
   endtask

   task automatic random_view(int iters, bit mirrored);
      logic [31:0] v;
      write_reg(REG_MAX_ITER, iters);
      write_reg(REG_MAGNIFY, $urandom_range(1, 8) * 32768);
      v = $urandom;
      write_reg(REG_X_CENTER, -32'sd134217728 - (signed'(v) >>> 4));
      v = $urandom;
      write_reg(REG_Y_CENTER, mirrored ? 32'd0 : signed'(v) >>> 4);
      write_reg(REG_H_RES, $urandom_range(1, 300));
      write_reg(REG_V_RES, $urandom_range(1, 300));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset view: corners, center of the set, out-of-frame pixels.
      send_pixel(1, 1);
      send_pixel(800, 600);
      send_pixel(400, 300);
      send_pixel(0, 0);
      send_pixel(8191, 8191);
      send_pixel(401, 301);
      finish_burst();

      // Largest limit and zoom, far off-center so every pixel escapes early.
      write_reg(REG_MAX_ITER, 32'h0000_FFFF);
      write_reg(REG_MAGNIFY, 32'hFFFF_FFFF);
      write_reg(REG_X_CENTER, 32'h7FFF_FFFF);
      write_reg(REG_Y_CENTER, 32'h8000_0000);
      send_pixel(1, 1);
      send_pixel(800, 600);
      send_pixel(4095, 17);
      finish_burst();

      // Zero limit, zero zoom, zero and oversized resolutions.
      write_reg(REG_MAX_ITER, 0);
      write_reg(REG_MAGNIFY, 0);
      write_reg(REG_X_CENTER, 32'h8000_0000);
      write_reg(REG_Y_CENTER, 0);
      write_reg(REG_H_RES, 8191);
      write_reg(REG_V_RES, 0);
      send_pixel(1, 1);
      send_pixel(2048, 5);
      send_pixel(4096, 4096);
      finish_burst();

      // Single-iteration limit and odd height: middle row mirrors onto itself.
      write_reg(REG_MAX_ITER, 1);
      write_reg(REG_MAGNIFY, 65536);
      write_reg(REG_X_CENTER, 0);
      write_reg(REG_H_RES, 1);
      write_reg(REG_V_RES, 601);
      send_pixel(1, 301);
      send_pixel(1, 1);
      finish_burst();

      // Random views; one phase runs without any idling.
      random_view(64, 1'b1);
      random_pixels(300);
      random_view(200, 1'b0);
      random_pixels(200);
      steady = 1'b1;
      random_view(32, 1'b1);
      random_pixels(300);
      steady = 1'b0;
      random_view($urandom_range(2, 100), 1'b0);
      random_pixels(300);

      drain();
      $display("covered %0d pixels, %0d results (%0d mirrored) in %0d cycles",
               pixels_sent, sb.results_seen, sb.mirrored_seen, cycles);
      $display("views swept limits 0..65535, zoom 0..max, both center extremes");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("[mandelbrot_escape_time_pixel] OK");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
         $display("[mandelbrot_escape_time_pixel] ERROR");
      end
      $finish;
   end

endmodule
